// ===== rtl/srt_pkg.sv =====
`timescale 1ns / 1ps
package srt_pkg;

  // Payload widths on the channels
  localparam int DATA_W = 32;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } srt_state_t;

  // Control shared by every cell of the row
  typedef struct packed {
    logic shift;  // move every stored value one cell toward the head
    logic hold;   // emitting: ignore any value arriving from the left
  } srt_ctl_t;

endpackage

// ===== rtl/srt_if.sv =====
`timescale 1ns / 1ps
// Input channel: one value per beat, last marks the end of a set
interface srt_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [srt_pkg::DATA_W-1:0] value;
  logic                              last;

  modport src (output valid, output value, output last, input ready);
  modport snk (input valid, input value, input last, output ready);
  modport mon (input valid, input value, input last, input ready);
endinterface

// Result channel: sorted values, final_res on the last beat of a set
interface srt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [srt_pkg::DATA_W-1:0] sorted_value;
  logic                              final_res;
  logic                              overflow;

  modport src (output valid, output sorted_value, output final_res, output overflow,
               input ready);
  modport snk (input valid, input sorted_value, input final_res, input overflow,
               output ready);
  modport mon (input valid, input sorted_value, input final_res, input overflow,
               input ready);
endinterface

// ===== rtl/srt_cell.sv =====
`timescale 1ns / 1ps
// One compare-and-swap cell: keeps the smaller of its stored value and the
// value arriving from the left, and passes the larger one to the right cell.
module srt_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srt_pkg::srt_ctl_t             ctl,
  input  logic                          win_valid,
  input  logic signed [VALUE_WIDTH-1:0] win_val,
  input  logic                          nb_valid,
  input  logic signed [VALUE_WIDTH-1:0] nb_val,
  output logic                          hold_valid,
  output logic signed [VALUE_WIDTH-1:0] hold_val,
  output logic                          wout_valid,
  output logic signed [VALUE_WIDTH-1:0] wout_val
);

  logic                          stv_r, stv_nxt;
  logic signed [VALUE_WIDTH-1:0] st_r, st_nxt;
  logic                          wv_r, wv_nxt;
  logic signed [VALUE_WIDTH-1:0] w_r, w_nxt;

  // Insert, or shift toward the head while emitting
  always_comb begin
    stv_nxt = stv_r;
    st_nxt  = st_r;
    wv_nxt  = 1'b0;
    w_nxt   = w_r;
    if (ctl.shift) begin
      stv_nxt = nb_valid;
      st_nxt  = nb_val;
    end else if (win_valid && !ctl.hold) begin
      if (!stv_r) begin
        stv_nxt = 1'b1;
        st_nxt  = win_val;
      end else if (win_val < st_r) begin
        st_nxt = win_val;
        wv_nxt = 1'b1;
        w_nxt  = st_r;
      end else begin
        wv_nxt = 1'b1;
        w_nxt  = win_val;
      end
    end
  end

  // Valid bits reset, values do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stv_r <= 1'b0;
      wv_r  <= 1'b0;
    end else begin
      stv_r <= stv_nxt;
      wv_r  <= wv_nxt;
    end
    st_r <= st_nxt;
    w_r  <= w_nxt;
  end

  assign hold_valid = stv_r;
  assign hold_val   = st_r;
  assign wout_valid = wv_r;
  assign wout_val   = w_r;

endmodule

// ===== rtl/merge_sorter.sv =====
`timescale 1ns / 1ps
// Sorter built as a row of CAPACITY compare-and-swap cells; values ripple one cell a cycle.
// Loading: one beat per cycle, in_ready high until the beat marked last.
// After last: settle, then one result beat per stored value at one per cycle (out_ready held).
// Reset (rst_n low, synchronous) empties the row and clears the count and overflow flag.
module merge_sorter #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  srt_in_if.snk         in_ch,
  srt_out_if.src        out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SET_W = $clog2(CAPACITY);

  srt_pkg::srt_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SET_W-1:0]    settle_r, settle_nxt;
  logic                drop_r, drop_nxt;
  srt_pkg::srt_ctl_t   ctl;

  logic                          in_beat, out_beat, full;
  logic signed [VALUE_WIDTH-1:0] v_in;

  logic                          cell_vld [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic                          wave_vld [CAPACITY+1];
  logic signed [VALUE_WIDTH-1:0] wave_val [CAPACITY+1];

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;
  assign full     = (count_r == CNT_W'(CAPACITY));

  // Take the low VALUE_WIDTH bits as two's complement, or sign-extend
  generate
    if (VALUE_WIDTH <= srt_pkg::DATA_W) begin : g_in_cut
      assign v_in = in_ch.value[VALUE_WIDTH-1:0];
    end else begin : g_in_ext
      assign v_in = VALUE_WIDTH'(in_ch.value);
    end
  endgenerate

  // Feed the head of the row; a beat beyond capacity is dropped
  assign wave_vld[0] = in_beat && !full;
  assign wave_val[0] = v_in;

  // Row of cells
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          nb_v;
      logic signed [VALUE_WIDTH-1:0] nb_d;
      if (i == CAPACITY - 1) begin : g_tail
        assign nb_v = 1'b0;
        assign nb_d = cell_val[i];
      end else begin : g_mid
        assign nb_v = cell_vld[i+1];
        assign nb_d = cell_val[i+1];
      end
      srt_cell #(
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .win_valid  (wave_vld[i]),
        .win_val    (wave_val[i]),
        .nb_valid   (nb_v),
        .nb_val     (nb_d),
        .hold_valid (cell_vld[i]),
        .hold_val   (cell_val[i]),
        .wout_valid (wave_vld[i+1]),
        .wout_val   (wave_val[i+1])
      );
    end
  endgenerate

  // Next state and counters
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    settle_nxt = settle_r;
    drop_nxt   = drop_r;
    unique case (state_r)
      srt_pkg::ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.last) begin
            state_nxt  = srt_pkg::ST_SETTLE;
            settle_nxt = '0;
          end
        end
      end
      srt_pkg::ST_SETTLE: begin
        settle_nxt = settle_r + SET_W'(1);
        if (settle_r == SET_W'(CAPACITY - 1)) begin
          state_nxt = srt_pkg::ST_EMIT;
        end
      end
      srt_pkg::ST_EMIT: begin
        if (out_beat) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = srt_pkg::ST_LOAD;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = srt_pkg::ST_LOAD;
    endcase
  end

  // Handshake and cell control
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    ctl.hold     = 1'b0;
    unique case (state_r)
      srt_pkg::ST_LOAD:   in_ch.ready  = 1'b1;
      srt_pkg::ST_SETTLE: ctl.hold     = 1'b0;
      srt_pkg::ST_EMIT: begin
        out_ch.valid = 1'b1;
        ctl.hold     = 1'b1;
      end
      default: in_ch.ready = 1'b0;
    endcase
    ctl.shift = out_beat;
  end

  // Result payload straight from the head cell
  generate
    if (VALUE_WIDTH >= srt_pkg::DATA_W) begin : g_out_cut
      assign out_ch.sorted_value = cell_val[0][srt_pkg::DATA_W-1:0];
    end else begin : g_out_ext
      assign out_ch.sorted_value = srt_pkg::DATA_W'(cell_val[0]);
    end
  endgenerate
  assign out_ch.final_res = (count_r == CNT_W'(1));
  assign out_ch.overflow  = drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= srt_pkg::ST_LOAD;
      count_r  <= '0;
      settle_r <= '0;
      drop_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      settle_r <= settle_nxt;
      drop_r   <= drop_nxt;
    end
  end

endmodule

// ===== rtl/srt_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks on the sorter
module srt_chk (
  input logic    clk,
  input logic    rst_n,
  srt_in_if.snk  in_ch,
  srt_out_if.src out_ch
);

  // Never load and emit at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("load and emit overlap");

  // A last beat closes loading and starts settling
  a_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> (!in_ch.ready && !out_ch.valid))
    else $error("no settle after last beat");

  // Emission continues until the final beat
  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.final_res) |=> out_ch.valid)
    else $error("emission stopped early");

  // The final beat hands back to loading
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.final_res) |=> (in_ch.ready && !out_ch.valid))
    else $error("not ready after final beat");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.sorted_value)))
    else $error("stalled result changed");

endmodule

bind merge_sorter srt_chk u_srt_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
